>>> hdl/afq_pkg.sv
// Shared types, command codes and reset constants of the aging transmit queue.
`timescale 1ns / 1ps

package afq_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int CNT_W = 6;
	localparam int ID_W = 16;
	localparam int DESC_W = 32;
	localparam int TIME_W = 32;
	localparam int SIZE_W = 6;
	localparam int DELAY_W = 31;
	localparam int CMD_W = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 31;

	localparam logic [CMD_W-1:0] CMD_ENQ = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DEQ = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd4;
	localparam logic [CMD_W-1:0] CMD_PURGE = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY = 1'b1;

	localparam logic [SIZE_W-1:0] MAX_SIZE_RST = 6'd32;
	localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 31'd10000000;

	localparam logic KIND_DROP = 1'b0;
	localparam logic KIND_RESP = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [TIME_W-1:0] now_time;
		logic [ID_W-1:0] packet_id;
		logic [DESC_W-1:0] descriptor;
	} afq_in_t;

	typedef struct packed {
		logic result_kind;
		logic ok;
		logic [ID_W-1:0] out_packet_id;
		logic [DESC_W-1:0] out_descriptor;
		logic [CNT_W-1:0] fill_count;
		logic is_empty;
		logic last;
	} afq_out_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [DESC_W-1:0] desc;
		logic [TIME_W-1:0] stamp;
	} afq_entry_t;

	typedef struct packed {
		logic remove_mode;
		logic found;
	} afq_judge_ctl_t;

endpackage

>>> hdl/afq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module afq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/afq_judge.sv
// Shared compare unit that decides whether a scanned entry leaves the queue.
`timescale 1ns / 1ps

module afq_judge (
	input logic [afq_pkg::TIME_W-1:0] now_time,
	input logic [afq_pkg::DELAY_W-1:0] max_delay,
	input logic [afq_pkg::ID_W-1:0] match_id,
	input afq_pkg::afq_judge_ctl_t ctl,
	input afq_pkg::afq_entry_t entry,
	output logic drop
);
	import afq_pkg::*;

	logic [TIME_W-1:0] age;
	logic aged;
	logic hit;

	// Age is taken modulo 2^32, so a clock that moved backward reads as very old.
	assign age = now_time - entry.stamp;
	assign aged = age >= {1'b0, max_delay};
	assign hit = !ctl.found && (entry.id == match_id);
	assign drop = ctl.remove_mode ? hit : aged;

endmodule

>>> hdl/aging_fifo_tx_queue_core.sv
// Top level of the aging transmit queue: sequencer, entry RAM and result register.
`timescale 1ns / 1ps

// Bounded, order-keeping transmit queue of (packet id, descriptor, arrival time).
// Entries live in a circular RAM; a command is taken only while the sequencer is
// idle. Enqueue, dequeue, peek and purge first walk the queue from head to tail,
// one entry per cycle through the RAM read port and the shared compare unit while
// no drop report waits for the result register, and compact it in place: kept
// entries are rewritten toward the head, aged ones (age >= max_delay) are dropped
// and each gives a drop report. Remove walks the queue the same way but drops only
// the first entry whose id matches, silently. Flush and unused command codes do
// not walk the queue. Every command ends with one response transfer that has last
// set. A drop report or response that finds the result register still occupied
// waits while out_ready is low. The entry RAM needs no clearing after reset: only
// entries below the fill count are ever read. Configuration writes are meant to
// happen while idle.
module aging_fifo_tx_queue_core #(
	parameter int QUEUE_DEPTH = afq_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [afq_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [afq_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input afq_pkg::afq_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output afq_pkg::afq_out_t out_data
);
	import afq_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN = 2'd2;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	// Control state.
	logic [1:0] state_q;
	logic [SIZE_W-1:0] max_size_q;
	logic [DELAY_W-1:0] max_delay_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic v_q;
	logic found_q;
	logic kept_any_q;
	logic out_valid_q;

	// Payload registers.
	logic [CMD_W-1:0] cmd_q;
	logic [TIME_W-1:0] now_q;
	logic [ID_W-1:0] pid_q;
	logic [DESC_W-1:0] desc_q;
	logic [ID_W-1:0] hd_id_q;
	logic [DESC_W-1:0] hd_desc_q;
	afq_out_t out_q;

	logic in_fire;
	logic can_emit;
	logic is_rem;
	logic drop;
	logic stall;
	logic scan_issue;
	logic scan_done;
	logic eval_go;
	logic keep_wr;
	logic drop_go;
	logic emit_drop;
	logic fin_go;
	logic [CNT_W-1:0] limit;
	logic [CNT_W-1:0] cnt_dec;
	logic enq_ok;
	logic ram_we;
	afq_entry_t ram_wdata;
	afq_entry_t ram_rdata;
	logic [$bits(afq_entry_t)-1:0] ram_rbits;
	afq_judge_ctl_t judge_ctl;

	logic resp_ok;
	logic [ID_W-1:0] resp_id;
	logic [DESC_W-1:0] resp_desc;
	logic [CNT_W-1:0] cnt_fin;
	logic head_adv;
	afq_out_t drop_rep;
	afq_out_t resp_rep;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// The result register can take a new result when it is empty or being drained.
	assign can_emit = !out_valid_q || out_ready;
	assign is_rem = (cmd_q == CMD_REMOVE);

	assign ram_rdata = afq_entry_t'(ram_rbits);

	assign judge_ctl.remove_mode = is_rem;
	assign judge_ctl.found = found_q;

	afq_judge u_judge (
		.now_time (now_q),
		.max_delay(max_delay_q),
		.match_id (pid_q),
		.ctl      (judge_ctl),
		.entry    (ram_rdata),
		.drop     (drop)
	);

	// An aged entry needs room in the result register; while it waits, the read
	// data register holds and no further read is issued.
	assign stall = v_q && drop && !is_rem && !can_emit;
	assign scan_issue = (state_q == ST_SCAN) && !stall && (rd_cnt_q < n_q);
	assign scan_done = (state_q == ST_SCAN) && !v_q && (rd_cnt_q == n_q);
	assign eval_go = (state_q == ST_SCAN) && v_q && !stall;
	assign keep_wr = eval_go && !drop;
	assign drop_go = eval_go && drop;
	assign emit_drop = drop_go && !is_rem;
	assign fin_go = (state_q == ST_FIN) && can_emit;

	assign limit = (max_size_q < DEPTH_CNT) ? max_size_q : DEPTH_CNT;
	assign enq_ok = (cmd_q == CMD_ENQ) && (cnt_q < limit);
	assign cnt_dec = cnt_q - 1'b1;

	// Kept entries and new entries both go to the write pointer, which after a
	// walk sits just past the last kept entry, i.e. at the tail.
	assign ram_we = keep_wr || (fin_go && enq_ok);
	always_comb begin
		if (keep_wr) begin
			ram_wdata = ram_rdata;
		end else begin
			ram_wdata.id = pid_q;
			ram_wdata.desc = desc_q;
			ram_wdata.stamp = now_q;
		end
	end

	afq_ram #(
		.WIDTH($bits(afq_entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_ptr_q),
		.wdata(ram_wdata),
		.re   (scan_issue),
		.raddr(rd_ptr_q),
		.rdata(ram_rbits)
	);

	// Finishing action of each command and its response fields.
	always_comb begin
		resp_ok = 1'b0;
		resp_id = '0;
		resp_desc = '0;
		cnt_fin = cnt_q;
		head_adv = 1'b0;
		unique case (cmd_q)
			CMD_ENQ: begin
				if (enq_ok) begin
					resp_ok = 1'b1;
					cnt_fin = cnt_q + 1'b1;
				end
			end
			CMD_DEQ: begin
				if (cnt_q != '0) begin
					resp_ok = 1'b1;
					resp_id = hd_id_q;
					resp_desc = hd_desc_q;
					cnt_fin = cnt_dec;
					head_adv = 1'b1;
				end
			end
			CMD_PEEK: begin
				if (cnt_q != '0) begin
					resp_ok = 1'b1;
					resp_id = hd_id_q;
					resp_desc = hd_desc_q;
				end
			end
			CMD_REMOVE: begin
				resp_ok = found_q;
			end
			CMD_FLUSH: begin
				resp_ok = 1'b1;
				cnt_fin = '0;
			end
			CMD_PURGE: begin
				resp_ok = 1'b1;
			end
			default: begin
				resp_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		drop_rep.result_kind = KIND_DROP;
		drop_rep.ok = 1'b0;
		drop_rep.out_packet_id = ram_rdata.id;
		drop_rep.out_descriptor = '0;
		drop_rep.fill_count = cnt_dec;
		drop_rep.is_empty = (cnt_dec == '0);
		drop_rep.last = 1'b0;

		resp_rep.result_kind = KIND_RESP;
		resp_rep.ok = resp_ok;
		resp_rep.out_packet_id = resp_id;
		resp_rep.out_descriptor = resp_desc;
		resp_rep.fill_count = cnt_fin;
		resp_rep.is_empty = (cnt_fin == '0);
		resp_rep.last = 1'b1;
	end

	// Control state of the sequencer, the queue pointers and the configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_size_q <= MAX_SIZE_RST;
			max_delay_q <= MAX_DELAY_RST;
			head_q <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q <= '0;
			n_q <= '0;
			rd_cnt_q <= '0;
			v_q <= 1'b0;
			found_q <= 1'b0;
			kept_any_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MAX_SIZE: max_size_q <= cfg_data[SIZE_W-1:0];
					CFG_MAX_DELAY: max_delay_q <= cfg_data[DELAY_W-1:0];
					default: ;
				endcase
			end

			if (emit_drop || fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						rd_ptr_q <= head_q;
						wr_ptr_q <= head_q;
						n_q <= cnt_q;
						rd_cnt_q <= '0;
						v_q <= 1'b0;
						found_q <= 1'b0;
						kept_any_q <= 1'b0;
						if (in_data.cmd == CMD_ENQ || in_data.cmd == CMD_DEQ ||
							in_data.cmd == CMD_PEEK || in_data.cmd == CMD_REMOVE ||
							in_data.cmd == CMD_PURGE) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						rd_ptr_q <= ptr_inc(rd_ptr_q);
						rd_cnt_q <= rd_cnt_q + 1'b1;
						v_q <= 1'b1;
					end else if (eval_go) begin
						v_q <= 1'b0;
					end
					if (keep_wr) begin
						wr_ptr_q <= ptr_inc(wr_ptr_q);
						kept_any_q <= 1'b1;
					end
					if (drop_go) begin
						cnt_q <= cnt_dec;
						if (is_rem) begin
							found_q <= 1'b1;
						end
					end
					if (scan_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						cnt_q <= cnt_fin;
						if (head_adv) begin
							head_q <= ptr_inc(head_q);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latched command, head entry captured during the walk, and the result register.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= in_data.cmd;
			now_q <= in_data.now_time;
			pid_q <= in_data.packet_id;
			desc_q <= in_data.descriptor;
		end
		// The first kept entry is the head once the walk is over.
		if (keep_wr && !kept_any_q) begin
			hd_id_q <= ram_rdata.id;
			hd_desc_q <= ram_rdata.desc;
		end
		if (emit_drop) begin
			out_q <= drop_rep;
		end else if (fin_go) begin
			out_q <= resp_rep;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_CNT)
		else $error("fill count exceeds the queue depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_cnt_q <= n_q && cnt_q <= n_q))
		else $error("walk ran past the entries it started with");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && stall) |=> ($stable(rd_ptr_q) && $stable(wr_ptr_q) && v_q))
		else $error("walk advanced while a drop report was waiting");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && cmd_q == CMD_DEQ && cnt_q != '0) |-> kept_any_q)
		else $error("dequeue without a captured head entry");

endmodule

>>> dv/aging_fifo_tx_queue_core_test.sv
// Self-checking testbench for the aging transmit queue core.
`timescale 1ns / 1ps

// The testbench keeps its own model of the queue. The model holds the entries, the two limit
// registers and a list of the results still to come. Every command transfer that the core
// accepts is run through the model at the accepting edge. That adds the aged-out drop reports,
// in queue order, and then the closing response to the list. A monitor compares every result
// transfer, field by field, with the oldest item on that list.
//
// Stimulus comes from a set of named tests that run in turn:
//   - commands on an empty queue, including the two unused command codes;
//   - basic enqueue, peek, remove, dequeue and flush at the widest field values;
//   - the time stamp wrapping past 2^32 and moving backward;
//   - a zero age limit, and size limits of zero and two;
//   - random traffic over several limit settings. Segments that favor filling the queue
//     alternate with segments that drain it, so the queue reaches its full depth, refuses
//     packets at the tail, and loses a whole queue of entries to one large time jump.
// The sender works in bursts with random gaps. The receiver changes its stall pattern from
// time to time: always ready, coin flip, fixed duty cycle, or mostly stalled.
module aging_fifo_tx_queue_core_test;
	import afq_pkg::*;

	localparam int QDEPTH = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	// Cycles allowed between the last response and a register write, and at the end.
	localparam int SETTLE_CYCLES = 4;
	localparam int END_SETTLE_CYCLES = 40;
	localparam int MAX_REPORTED = 10;

	// The command field has two codes that the core does not use.
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	// Traffic profiles for the random part.
	localparam int PROFILE_FILL = 0;
	localparam int PROFILE_MIXED = 1;
	localparam int PROFILE_DRAIN = 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_MAX_SIZE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	afq_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	afq_out_t out_data;

	// Model state: the held entries in queue order and the two limit registers.
	afq_entry_t model_entries[$];
	logic [SIZE_W-1:0] lim_size = MAX_SIZE_RST;
	logic [DELAY_W-1:0] lim_delay = MAX_DELAY_RST;

	// Results still owed by the core, oldest first.
	afq_out_t pending_results[$];
	afq_out_t want_result;

	int err_count = 0;
	int cycle_count = 0;
	int commands_sent = 0;
	int settings_used = 1;
	int drops_seen = 0;
	int responses_seen = 0;
	int peak_fill = 0;
	int burst_left = 0;

	// State of the receiver's stall pattern.
	int ready_mode = 0;
	int ready_span = 0;
	int ready_phase = 0;

	aging_fifo_tx_queue_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #10 clk = ~clk;

	// Stop a hung run. The limit is several times the slowest correct run: every command walks
	// a full queue and emits a drop report for each entry, and each report waits out a long stall.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending.", cycle_count,
				pending_results.size());
			$display("aging_fifo_tx_queue_core verification failed");
			$finish;
		end
	end

	// Receiver: the stall pattern changes at random intervals. Each pattern in turn keeps
	// out_ready high, flips a coin, runs a fixed duty cycle, or stalls most of the time.
	always @(posedge clk) begin
		if (ready_span == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_span = $urandom_range(16, 96);
			ready_phase = 0;
		end else begin
			ready_span--;
		end
		ready_phase++;
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (ready_phase % 5) < 2;
			default: out_ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	function automatic void log_failure(string what, afq_out_t want, afq_out_t got);
		err_count++;
		if (err_count <= MAX_REPORTED) begin
			$display("%0t: %s", $realtime, what);
			$display("  expected kind=%0d ok=%0d id=%h desc=%h fill=%0d empty=%0d last=%0d",
				want.result_kind, want.ok, want.out_packet_id, want.out_descriptor,
				want.fill_count, want.is_empty, want.last);
			$display("  actual   kind=%0d ok=%0d id=%h desc=%h fill=%0d empty=%0d last=%0d",
				got.result_kind, got.ok, got.out_packet_id, got.out_descriptor,
				got.fill_count, got.is_empty, got.last);
		end
	endfunction

	// Result monitor: each result transfer is matched against the oldest pending result.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				log_failure("result transfer with no result pending", '0, out_data);
			end else begin
				want_result = pending_results[0];
				pending_results.delete(0);
				if (out_data.result_kind !== want_result.result_kind
						|| out_data.ok !== want_result.ok
						|| out_data.out_packet_id !== want_result.out_packet_id
						|| out_data.out_descriptor !== want_result.out_descriptor
						|| out_data.fill_count !== want_result.fill_count
						|| out_data.is_empty !== want_result.is_empty
						|| out_data.last !== want_result.last) begin
					log_failure("result transfer differs from prediction", want_result,
						out_data);
				end
				if (want_result.result_kind == KIND_DROP) begin
					drops_seen++;
				end else begin
					responses_seen++;
				end
			end
		end
	end

	// Apply one command to the model and queue the results it should produce. Enqueue,
	// dequeue, peek and purge first remove every aged entry; remove and flush do not.
	function automatic void predict_queue_results(afq_in_t cmd_item);
		afq_out_t res;
		afq_entry_t fresh;
		int idx;
		int fill_cap;
		logic [TIME_W-1:0] age;
		logic resp_ok;
		logic [ID_W-1:0] resp_id;
		logic [DESC_W-1:0] resp_desc;
		resp_ok = 1'b0;
		resp_id = '0;
		resp_desc = '0;
		if (cmd_item.cmd == CMD_ENQ || cmd_item.cmd == CMD_DEQ || cmd_item.cmd == CMD_PEEK
				|| cmd_item.cmd == CMD_PURGE) begin
			idx = 0;
			while (idx < model_entries.size()) begin
				// The age is a modular difference, so a time stamp that moved backward gives
				// a huge age and ages the entry out.
				age = cmd_item.now_time - model_entries[idx].stamp;
				if (age >= TIME_W'(lim_delay)) begin
					res = '0;
					res.result_kind = KIND_DROP;
					res.out_packet_id = model_entries[idx].id;
					model_entries.delete(idx);
					res.fill_count = CNT_W'(model_entries.size());
					res.is_empty = (model_entries.size() == 0);
					pending_results = {pending_results, res};
				end else begin
					idx++;
				end
			end
		end
		case (cmd_item.cmd)
			CMD_ENQ: begin
				// A size limit above the queue depth is clamped to the depth.
				fill_cap = (int'(lim_size) < QDEPTH) ? int'(lim_size) : QDEPTH;
				if (model_entries.size() < fill_cap) begin
					fresh.id = cmd_item.packet_id;
					fresh.desc = cmd_item.descriptor;
					fresh.stamp = cmd_item.now_time;
					model_entries = {model_entries, fresh};
					resp_ok = 1'b1;
				end
			end
			CMD_DEQ, CMD_PEEK: begin
				if (model_entries.size() > 0) begin
					resp_ok = 1'b1;
					resp_id = model_entries[0].id;
					resp_desc = model_entries[0].desc;
					if (cmd_item.cmd == CMD_DEQ) begin
						model_entries.delete(0);
					end
				end
			end
			CMD_REMOVE: begin
				// Only the first entry with a matching id goes away.
				for (idx = 0; idx < model_entries.size(); idx++) begin
					if (model_entries[idx].id == cmd_item.packet_id) begin
						model_entries.delete(idx);
						resp_ok = 1'b1;
						break;
					end
				end
			end
			CMD_FLUSH: begin
				model_entries.delete();
				resp_ok = 1'b1;
			end
			CMD_PURGE: resp_ok = 1'b1;
			default: ;
		endcase
		if (model_entries.size() > peak_fill) begin
			peak_fill = model_entries.size();
		end
		res = '0;
		res.result_kind = KIND_RESP;
		res.ok = resp_ok;
		res.out_packet_id = resp_id;
		res.out_descriptor = resp_desc;
		res.fill_count = CNT_W'(model_entries.size());
		res.is_empty = (model_entries.size() == 0);
		res.last = 1'b1;
		pending_results = {pending_results, res};
	endfunction

	// Offer one command and hold it until the core takes it. Called at a rising edge. Valid
	// stays high into the next command unless the burst ends here and a gap follows.
	task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] stamp,
			input logic [ID_W-1:0] pid, input logic [DESC_W-1:0] desc);
		afq_in_t cmd_item;
		int gap;
		cmd_item.cmd = cmd;
		cmd_item.now_time = stamp;
		cmd_item.packet_id = pid;
		cmd_item.descriptor = desc;
		in_valid <= 1'b1;
		in_data <= cmd_item;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		predict_queue_results(cmd_item);
		commands_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// A new burst, long or short, after a gap. Gaps run up to the length of a full
			// walk of the queue, so they land on every stage of the core's work.
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid, wait until every predicted result has been transferred, then let the core
	// settle back to idle.
	task automatic finish_phase(input int settle);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (settle) @(posedge clk);
	endtask

	// Write both limit registers on back-to-back edges. The core must be idle when this runs.
	task automatic program_limits(input logic [SIZE_W-1:0] size_val,
			input logic [DELAY_W-1:0] delay_val);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAX_SIZE;
		cfg_data <= CFG_DATA_W'(size_val);
		@(posedge clk);
		cfg_index <= CFG_MAX_DELAY;
		cfg_data <= delay_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_size = size_val;
		lim_delay = delay_val;
		settings_used++;
		@(posedge clk);
	endtask

	// Commands on an empty queue. The limits still hold their reset values here.
	task automatic test_empty_queue();
		send_command(CMD_DEQ, 32'd0, 16'hFFFF, 32'hFFFF_FFFF);
		send_command(CMD_PEEK, 32'd0, 16'h0000, 32'h0);
		send_command(CMD_REMOVE, 32'd0, 16'hFFFF, 32'h0);
		send_command(CMD_PURGE, 32'd0, 16'h0000, 32'h0);
		send_command(CMD_FLUSH, 32'd0, 16'h0000, 32'h0);
		send_command(CMD_UNUSED_LO, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_command(CMD_UNUSED_HI, 32'd0, 16'h0000, 32'h0);
		finish_phase(SETTLE_CYCLES);
	endtask

	// Plain queue behavior. The same id is queued twice so that remove must take the first.
	task automatic test_basic_ops();
		send_command(CMD_ENQ, 32'd100, 16'hFFFF, 32'hFFFF_FFFF);
		send_command(CMD_ENQ, 32'd100, 16'h0000, 32'h0000_0000);
		send_command(CMD_ENQ, 32'd200, 16'h1234, 32'h5A5A_A5A5);
		send_command(CMD_ENQ, 32'd210, 16'hFFFF, 32'h0000_0001);
		send_command(CMD_REMOVE, 32'd220, 16'hFFFF, 32'h0);
		send_command(CMD_PEEK, 32'd230, 16'h0000, 32'h0);
		send_command(CMD_REMOVE, 32'd240, 16'h7777, 32'h0);
		send_command(CMD_DEQ, 32'd250, 16'h0000, 32'h0);
		// An unused code on a queue that holds entries must leave them alone.
		send_command(CMD_UNUSED_HI, 32'hFFFF_0000, 16'h0000, 32'h0);
		send_command(CMD_FLUSH, 32'd260, 16'h0000, 32'h0);
		finish_phase(SETTLE_CYCLES);
	endtask

	// The clock wraps past 2^32 and the entry survives; a later time that moves backward
	// makes the entry look ancient, and it ages out.
	task automatic test_time_wrap();
		send_command(CMD_ENQ, 32'hFFFF_FFF0, 16'h00AA, 32'hC0DE_0001);
		send_command(CMD_PURGE, 32'h0000_0010, 16'h0000, 32'h0);
		send_command(CMD_PURGE, 32'hFFFF_FF00, 16'h0000, 32'h0);
		finish_phase(SETTLE_CYCLES);
	endtask

	// With a zero age limit every held entry ages out at the next enqueue or purge. Remove
	// does not purge, so it still finds its entry.
	task automatic test_zero_delay();
		program_limits(SIZE_W'(32), '0);
		send_command(CMD_ENQ, 32'd5, 16'h0101, 32'h1111_1111);
		send_command(CMD_ENQ, 32'd5, 16'h0202, 32'h2222_2222);
		send_command(CMD_REMOVE, 32'd5, 16'h0202, 32'h0);
		send_command(CMD_ENQ, 32'd6, 16'h0303, 32'h3333_3333);
		send_command(CMD_PURGE, 32'd6, 16'h0000, 32'h0);
		finish_phase(SETTLE_CYCLES);
	endtask

	// A size limit of zero refuses everything. A limit of two refuses the third packet.
	task automatic test_size_limits();
		program_limits('0, DELAY_W'(31'h7FFF_FFFF));
		send_command(CMD_ENQ, 32'd1000, 16'h0A0A, 32'hAAAA_0000);
		finish_phase(SETTLE_CYCLES);
		program_limits(SIZE_W'(2), DELAY_W'(31'h7FFF_FFFF));
		send_command(CMD_ENQ, 32'd1000, 16'h0B01, 32'hBBBB_0001);
		send_command(CMD_ENQ, 32'd1001, 16'h0B02, 32'hBBBB_0002);
		send_command(CMD_ENQ, 32'd1002, 16'h0B03, 32'hBBBB_0003);
		send_command(CMD_FLUSH, 32'd1003, 16'h0000, 32'h0);
		finish_phase(SETTLE_CYCLES);
	endtask

	function automatic logic [CMD_W-1:0] pick_command(input int profile);
		int roll;
		int enq_cut;
		int deq_cut;
		roll = $urandom_range(0, 99);
		enq_cut = (profile == PROFILE_FILL) ? 70 : (profile == PROFILE_MIXED) ? 35 : 15;
		deq_cut = (profile == PROFILE_DRAIN) ? enq_cut + 35 : enq_cut + 12;
		if (roll < enq_cut) return CMD_ENQ;
		if (roll < deq_cut) return CMD_DEQ;
		if (roll < deq_cut + 8) return CMD_PEEK;
		if (roll < deq_cut + 20) return CMD_REMOVE;
		if (roll < 94) return CMD_PURGE;
		if (roll < 97) return CMD_FLUSH;
		return $urandom_range(0, 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
	endfunction

	// Random traffic over several limit settings, the extremes among them. Within a setting,
	// segments of one profile follow each other. Time mostly creeps forward in steps that
	// are small next to the age limit; now and then it jumps past the limit or steps back.
	task automatic test_random_traffic();
		int unsigned phase_sizes[7] = '{32, 63, 5, 0, 20, 33, 1};
		int unsigned phase_delays[7] = '{400, 5000, 250, 32'h7FFF_FFFF, 0, 0, 100};
		int phase_counts[7] = '{90, 100, 70, 30, 40, 60, 60};
		int unsigned delay_val;
		int ph;
		int n;
		int profile;
		int seg_left;
		int roll;
		logic [TIME_W-1:0] clock_now;
		logic [CMD_W-1:0] cmd;
		logic [ID_W-1:0] pid;
		profile = PROFILE_MIXED;
		for (ph = 0; ph < 7; ph++) begin
			delay_val = phase_delays[ph];
			// One setting uses a random, large age limit.
			if (ph == 5) begin
				delay_val = $urandom_range(32'h0010_0000, 32'h7FFF_FFFE);
			end
			program_limits(SIZE_W'(phase_sizes[ph]), DELAY_W'(delay_val));
			clock_now = $urandom;
			seg_left = 0;
			for (n = 0; n < phase_counts[ph]; n++) begin
				if (seg_left == 0) begin
					profile = $urandom_range(PROFILE_FILL, PROFILE_DRAIN);
					seg_left = $urandom_range(10, 40);
				end
				seg_left--;
				roll = $urandom_range(0, 99);
				if (roll < 3) begin
					clock_now += lim_delay + $urandom_range(0, 1000);
				end else if (roll < 5) begin
					clock_now -= $urandom_range(1, 5000);
				end else begin
					clock_now += $urandom_range(0,
						lim_delay / ((profile == PROFILE_FILL) ? 64 : 6) + 1);
				end
				cmd = pick_command(profile);
				// A small pool of ids makes duplicates, and so first-match removes, common.
				pid = $urandom_range(0, 1) ? ID_W'($urandom) : ID_W'($urandom_range(0, 15));
				if (cmd == CMD_REMOVE && model_entries.size() > 0
						&& $urandom_range(0, 9) < 6) begin
					pid = model_entries[$urandom_range(0, model_entries.size() - 1)].id;
				end
				send_command(cmd, clock_now, pid, $urandom);
			end
			finish_phase(SETTLE_CYCLES);
		end
	endtask

	initial begin
		afq_out_t leftover;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_basic_ops();
		test_time_wrap();
		test_zero_delay();
		test_size_limits();
		test_random_traffic();

		finish_phase(END_SETTLE_CYCLES);
		while (pending_results.size() != 0) begin
			leftover = pending_results[0];
			pending_results.delete(0);
			log_failure("predicted result never transferred", leftover, '0);
		end
		$display("Sent %0d commands over %0d limit settings; checked %0d responses and %0d",
			commands_sent, settings_used, responses_seen, drops_seen);
		$display("aged-out drop reports, peak queue fill %0d, %0d failures.", peak_fill,
			err_count);
		if (err_count == 0) begin
			$display("aging_fifo_tx_queue_core verification clean");
		end else begin
			$display("aging_fifo_tx_queue_core verification failed");
		end
		$finish;
	end

endmodule

>>> aging_fifo_tx_queue_core.f
hdl/afq_pkg.sv
hdl/afq_ram.sv
hdl/afq_judge.sv
hdl/aging_fifo_tx_queue_core.sv
dv/aging_fifo_tx_queue_core_test.sv
